[rtl/core/cdll_pkg.sv]
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and codes for the cursor linked list core.
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam logic [2:0] KIND_INS_BEFORE = 3'd0;
  localparam logic [2:0] KIND_INS_AFTER  = 3'd1;
  localparam logic [2:0] KIND_DELETE     = 3'd2;
  localparam logic [2:0] KIND_FIRST      = 3'd3;
  localparam logic [2:0] KIND_LAST       = 3'd4;
  localparam logic [2:0] KIND_MOVE       = 3'd5;
  localparam logic [2:0] KIND_SEARCH     = 3'd6;
  localparam logic [2:0] KIND_CLEAR      = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_END      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_LATCH     = 4'd1,  // capture item, start reads at the cursor
    CMD_ALLOC     = 4'd2,  // take a node, write it, read cursor links
    CMD_LINK      = 4'd3,  // fix neighbor links for insert
    CMD_DEL       = 4'd4,  // unlink cursor node using read links
    CMD_JUMP      = 4'd5,  // cursor to head or tail
    CMD_WALK_RD   = 4'd6,  // issue read at the walk pointer
    CMD_WALK_STEP = 4'd7,  // consume read data of the walk
    CMD_CLEAR     = 4'd8,
    CMD_RD_CUR    = 4'd9,  // read value at the cursor for the result
    CMD_RESULT    = 4'd10
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
  } dp_ctrl_t;

  typedef struct packed {
    logic       cursor_null;  // cursor invalid
    logic       pool_full;
    logic       walk_done;    // move or search finished
  } dp_stat_t;

endpackage

[rtl/core/cursor_doubly_linked_list_core.sv]
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_core
// Doubly linked list with cursor over a fixed node pool.
// ----------------------------------------------------------------------------
// One item at a time. First, last, delete and clear, a move or search on an
// empty list, a move by zero and an insert into a full pool pass through the
// dispatch, cursor read and result states to the output; other inserts add a
// link update state. Move and search add a read and a step state per node
// visited, as each link step is a registered read of the node memories. The
// result waits in the output register until transferred, and the next input
// is taken in the cycle after that.
module cursor_doubly_linked_list_core
  import cdll_pkg::*;
#(
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 32
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic signed [10:0]    in_step,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [VALUE_BITS-1:0] out_current_value,
  output logic [$clog2(NODES+1)-1:0] out_count,
  output logic                  out_cursor_valid
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  cdll_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_kind, .in_stall, .out_valid, .out_stall,
    .ctrl, .stat
  );

  cdll_dp #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .in_kind, .in_value, .in_step(in_step), .ctrl, .stat,
    .out_status, .out_current_value, .out_count, .out_cursor_valid
  );

endmodule

[rtl/core/cdll_ctrl.sv]
// ----------------------------------------------------------------------------
// cdll_ctrl
// Sequencer that steps the datapath through one operation per item.
// ----------------------------------------------------------------------------
module cdll_ctrl
  import cdll_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_kind,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_ctrl_t   ctrl,
  input  dp_stat_t   stat
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_ALLOC = 9'b000000100,
    S_LINK  = 9'b000001000,
    S_WRD   = 9'b000010000,
    S_WSTEP = 9'b000100000,
    S_RDCUR = 9'b001000000,
    S_RES   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_INS_BEFORE;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ctrl.cmd  = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.cmd  = CMD_LATCH;
          kind_nxt  = in_kind;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (kind_r)
          KIND_INS_BEFORE, KIND_INS_AFTER: begin
            if (stat.pool_full) state_nxt = S_RDCUR;
            else begin
              ctrl.cmd  = CMD_ALLOC;
              state_nxt = S_LINK;
            end
          end
          KIND_DELETE: begin
            if (!stat.cursor_null) ctrl.cmd = CMD_DEL;
            state_nxt = S_RDCUR;
          end
          KIND_FIRST, KIND_LAST: begin
            ctrl.cmd  = CMD_JUMP;
            state_nxt = S_RDCUR;
          end
          KIND_MOVE, KIND_SEARCH: begin
            state_nxt = stat.walk_done ? S_RDCUR : S_WSTEP;
            if (!stat.walk_done) ctrl.cmd = CMD_WALK_RD;
          end
          default: begin
            ctrl.cmd  = CMD_CLEAR;
            state_nxt = S_RDCUR;
          end
        endcase
      end
      S_LINK: begin
        ctrl.cmd  = CMD_LINK;
        state_nxt = S_RDCUR;
      end
      S_WRD: begin
        if (stat.walk_done) state_nxt = S_RDCUR;
        else begin
          ctrl.cmd  = CMD_WALK_RD;
          state_nxt = S_WSTEP;
        end
      end
      S_WSTEP: begin
        ctrl.cmd  = CMD_WALK_STEP;
        state_nxt = S_WRD;
      end
      S_ALLOC: state_nxt = S_LINK;
      S_RDCUR: begin
        ctrl.cmd  = CMD_RD_CUR;
        state_nxt = S_RES;
      end
      S_RES: begin
        ctrl.cmd  = CMD_RESULT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/cdll_dp.sv]
// ----------------------------------------------------------------------------
// cdll_dp
// Node pool memories, list pointers, free stack and walk logic.
// ----------------------------------------------------------------------------
module cdll_dp
  import cdll_pkg::*;
#(
  parameter int NODES      = 256,
  parameter int VALUE_BITS = 32
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            in_kind,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [10:0]           in_step,
  input  dp_ctrl_t              ctrl,
  output dp_stat_t              stat,
  output logic [2:0]            out_status,
  output logic [VALUE_BITS-1:0] out_current_value,
  output logic [$clog2(NODES+1)-1:0] out_count,
  output logic                  out_cursor_valid
);

  localparam int AW = $clog2(NODES);
  localparam int PW = $clog2(NODES+1);
  localparam logic [PW-1:0] NIL = PW'(NODES);

  // Node memories; one read port each, registered.
  logic [VALUE_BITS-1:0] val_mem [NODES];
  logic [PW-1:0]         nxt_mem [NODES];
  logic [PW-1:0]         prv_mem [NODES];
  logic [AW-1:0]         free_mem [NODES];

  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt, fresh_r, fresh_nxt, ftop_r, ftop_nxt;
  logic [PW-1:0] walk_r, walk_nxt, node_r, node_nxt;
  logic [10:0]   left_r, left_nxt;
  logic [PW-1:0] wcnt_r, wcnt_nxt;
  logic [2:0]    kind_r, kind_nxt, st_r, st_nxt;
  logic          done_r, done_nxt, neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;

  // Registered reads.
  logic [VALUE_BITS-1:0] rd_val;
  logic [PW-1:0]         rd_nxt, rd_prv;
  logic [AW-1:0]         rd_free;
  logic [AW-1:0]         rd_addr;

  // Write ports (at most one per memory per cycle).
  logic                  wv_en, wn_en, wp_en, wn2_en, wp2_en, wf_en;
  logic [AW-1:0]         wv_a, wn_a, wp_a, wn2_a, wp2_a;
  logic [VALUE_BITS-1:0] wv_d;
  logic [PW-1:0]         wn_d, wp_d, wn2_d, wp2_d;

  logic [AW-1:0] free_rd_a;

  always_ff @(posedge clk) begin
    rd_val  <= val_mem[rd_addr];
    rd_nxt  <= nxt_mem[rd_addr];
    rd_prv  <= prv_mem[rd_addr];
    rd_free <= free_mem[free_rd_a];
    if (wv_en) val_mem[wv_a] <= wv_d;
    if (wn_en) nxt_mem[wn_a] <= wn_d;
    else if (wn2_en) nxt_mem[wn2_a] <= wn2_d;
    if (wp_en) prv_mem[wp_a] <= wp_d;
    else if (wp2_en) prv_mem[wp2_a] <= wp2_d;
    if (wf_en) free_mem[ftop_r[AW-1:0]] <= cur_r[AW-1:0];
  end

  logic [10:0] mag_neg;
  logic [PW-1:0] new_node;
  assign mag_neg  = 11'(~in_step + 11'd1);
  assign free_rd_a = AW'(ftop_r - PW'(1));
  assign new_node = (ftop_r != '0) ? PW'(rd_free) : fresh_r;

  assign stat.cursor_null = (cur_r == NIL);
  assign stat.pool_full   = (ftop_r == '0) && (fresh_r == NIL);
  assign stat.walk_done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NIL;
      tail_r  <= NIL;
      cur_r   <= NIL;
      cnt_r   <= '0;
      fresh_r <= '0;
      ftop_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
      ftop_r  <= ftop_nxt;
    end
    walk_r <= walk_nxt;
    node_r <= node_nxt;
    left_r <= left_nxt;
    wcnt_r <= wcnt_nxt;
    kind_r <= kind_nxt;
    st_r   <= st_nxt;
    done_r <= done_nxt;
    neg_r  <= neg_nxt;
    key_r  <= key_nxt;
  end

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r; cnt_nxt = cnt_r;
    fresh_nxt = fresh_r; ftop_nxt = ftop_r;
    walk_nxt = walk_r; node_nxt = node_r; left_nxt = left_r; wcnt_nxt = wcnt_r;
    kind_nxt = kind_r; st_nxt = st_r; done_nxt = done_r; neg_nxt = neg_r;
    key_nxt = key_r;
    rd_addr = cur_r[AW-1:0];
    wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0; wn2_en = 1'b0; wp2_en = 1'b0;
    wf_en = 1'b0;
    wv_a = '0; wn_a = '0; wp_a = '0; wn2_a = '0; wp2_a = '0;
    wv_d = '0; wn_d = '0; wp_d = '0; wn2_d = '0; wp2_d = '0;
    unique case (ctrl.cmd)
      CMD_LATCH: begin
        kind_nxt = in_kind;
        key_nxt  = in_value;
        st_nxt   = ST_OK;
        walk_nxt = cur_r;
        wcnt_nxt = '0;
        neg_nxt  = in_step[10];
        left_nxt = in_step[10] ? mag_neg : in_step;
        done_nxt = 1'b0;
        if (cur_r == NIL) begin
          done_nxt = 1'b1;
          st_nxt   = ST_EMPTY;
        end else if (in_kind == KIND_MOVE && in_step == '0) begin
          done_nxt = 1'b1;
        end
        if ((in_kind == KIND_INS_BEFORE || in_kind == KIND_INS_AFTER)) begin
          st_nxt = ((ftop_r == '0) && (fresh_r == NIL)) ? ST_FULL : ST_OK;
        end
      end
      CMD_ALLOC: begin
        // Cursor links were read in the previous cycle.
        node_nxt = new_node;
        if (ftop_r != '0) ftop_nxt = ftop_r - PW'(1);
        else fresh_nxt = fresh_r + PW'(1);
        cnt_nxt = cnt_r + PW'(1);
        wv_en = 1'b1; wv_a = new_node[AW-1:0]; wv_d = key_r;
        wn_en = 1'b1; wn_a = new_node[AW-1:0];
        wp_en = 1'b1; wp_a = new_node[AW-1:0];
        if (cur_r == NIL) begin
          wn_d = NIL; wp_d = NIL;
          head_nxt = new_node; tail_nxt = new_node;
        end else if (kind_r == KIND_INS_BEFORE) begin
          wp_d = rd_prv; wn_d = cur_r;
          if (rd_prv == NIL) head_nxt = new_node;
        end else begin
          wn_d = rd_nxt; wp_d = cur_r;
          if (rd_nxt == NIL) tail_nxt = new_node;
        end
        walk_nxt = (kind_r == KIND_INS_BEFORE) ? rd_prv : rd_nxt;
      end
      CMD_LINK: begin
        if (cur_r != NIL) begin
          if (kind_r == KIND_INS_BEFORE) begin
            wp_en = 1'b1; wp_a = cur_r[AW-1:0]; wp_d = node_r;
            if (walk_r != NIL) begin
              wn_en = 1'b1; wn_a = walk_r[AW-1:0]; wn_d = node_r;
            end
          end else begin
            wn_en = 1'b1; wn_a = cur_r[AW-1:0]; wn_d = node_r;
            if (walk_r != NIL) begin
              wp_en = 1'b1; wp_a = walk_r[AW-1:0]; wp_d = node_r;
            end
          end
        end
        cur_nxt = node_r;
      end
      CMD_DEL: begin
        if (rd_prv != NIL) begin
          wn_en = 1'b1; wn_a = rd_prv[AW-1:0]; wn_d = rd_nxt;
          cur_nxt = rd_prv;
        end else begin
          cur_nxt = rd_nxt; head_nxt = rd_nxt;
        end
        if (rd_nxt != NIL) begin
          wp_en = 1'b1; wp_a = rd_nxt[AW-1:0]; wp_d = rd_prv;
        end else tail_nxt = rd_prv;
        wf_en = 1'b1;
        ftop_nxt = ftop_r + PW'(1);
        if (cnt_r != '0) cnt_nxt = cnt_r - PW'(1);
      end
      CMD_JUMP: begin
        cur_nxt = (kind_r == KIND_FIRST) ? head_r : tail_r;
        st_nxt  = (cur_nxt != NIL) ? ST_OK : ST_EMPTY;
      end
      CMD_WALK_RD: rd_addr = walk_r[AW-1:0];
      CMD_WALK_STEP: begin
        if (kind_r == KIND_SEARCH) begin
          if (rd_val == key_r) begin
            cur_nxt = walk_r; done_nxt = 1'b1;
          end else if (rd_nxt == NIL || wcnt_r == NIL - PW'(1)) begin
            st_nxt = ST_NOTFOUND; done_nxt = 1'b1;
          end else begin
            walk_nxt = rd_nxt; wcnt_nxt = wcnt_r + PW'(1);
          end
        end else begin
          walk_nxt = neg_r ? rd_prv : rd_nxt;
          left_nxt = left_r - 11'd1;
          if (walk_nxt == NIL) begin
            cur_nxt = neg_r ? head_r : tail_r;
            st_nxt = ST_END; done_nxt = 1'b1;
          end else if (left_nxt == '0) begin
            cur_nxt = walk_nxt; done_nxt = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        head_nxt = NIL; tail_nxt = NIL; cur_nxt = NIL;
        cnt_nxt = '0; fresh_nxt = '0; ftop_nxt = '0;
        // Clearing an empty list still answers ok.
        st_nxt = ST_OK;
      end
      CMD_RD_CUR: rd_addr = cur_r[AW-1:0];
      default: ;
    endcase
  end

  // Result register, loaded from the read of the cursor node.
  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_RESULT) begin
      out_status        <= st_r;
      out_current_value <= (cur_r != NIL) ? rd_val : '0;
      out_count         <= cnt_r;
      out_cursor_valid  <= (cur_r != NIL);
    end
  end

endmodule
